// ----- hdl/rsk_pkg.sv -----
// Shared types and constants for the RTP stream key table.
package rsk_pkg;

  localparam int TableDepthDef = 512;
  localparam int KeyBytes      = 40;
  localparam int KeyBits       = KeyBytes * 8;
  localparam int SsrcW         = 32;
  localparam int CountOutW     = 10;
  localparam int CmdQDepth     = 2;
  localparam int ResQDepth     = 2;

  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_RESET  = 2'd2;

  localparam logic [2:0] ST_EXISTING = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_RTCP     = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  localparam logic [6:0] RTCP_PT_LO = 7'd72;
  localparam logic [6:0] RTCP_PT_HI = 7'd76;

  localparam logic [5:0] LEN_V4 = 6'd12;
  localparam logic [5:0] LEN_V6 = 6'd36;

  localparam logic       CFG_SSRC_JOIN = 1'b0;
  localparam logic       CFG_EXCL_PT   = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic               rtcp;
    logic               v6;
    logic               pt_in_key;
    logic [5:0]         key_len;
    logic [6:0]         pt;
    logic [SsrcW-1:0]   ssrc;
    logic [KeyBits-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [CountOutW-1:0] stream_count;
    logic                 ssrc_match;
    logic                 pt_mismatch;
  } res_t;

endpackage

// ----- hdl/rsk_fifo.sv -----
// Small register queue used between the pipeline parts.
module rsk_fifo
  import rsk_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ----- hdl/rsk_front.sv -----
// Front end: classifies each word and builds the byte key.
module rsk_front
  import rsk_pkg::*;
(
  input  logic [1:0]  opcode,
  input  logic        is_ipv6,
  input  logic [63:0] src_addr_hi,
  input  logic [63:0] src_addr_lo,
  input  logic [63:0] dst_addr_hi,
  input  logic [63:0] dst_addr_lo,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [6:0]  rtp_pt,
  input  logic [31:0] sync_source,
  input  logic        is_dtmf,
  input  logic        excl_pt,
  output cmd_t        cmd
);

  logic       pt_in;
  logic [7:0] pt_byte;

  assign pt_in   = !is_dtmf && !excl_pt;
  assign pt_byte = pt_in ? {1'b0, rtp_pt} : 8'd0;

  always_comb begin
    cmd           = '0;
    cmd.op        = opcode;
    cmd.rtcp      = (rtp_pt >= RTCP_PT_LO) && (rtp_pt <= RTCP_PT_HI);
    cmd.v6        = is_ipv6;
    cmd.pt_in_key = pt_in;
    cmd.key_len   = (is_ipv6 ? LEN_V6 : LEN_V4) + {5'd0, pt_in};
    cmd.pt        = rtp_pt;
    cmd.ssrc      = sync_source;
    if (is_ipv6) begin
      cmd.key = {src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo,
                 src_port, dst_port, pt_byte, 24'd0};
    end else begin
      cmd.key = {src_addr_lo[31:0], dst_addr_lo[31:0], src_port, dst_port,
                 pt_byte, 216'd0};
    end
  end

endmodule

// ----- hdl/rsk_back.sv -----
// Back end: table memory, sequential key scan, append and count update.
module rsk_back
  import rsk_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic ssrc_join,
  input  cmd_t cmd,
  input  logic cmd_empty,
  output logic cmd_pop,
  output res_t res,
  output logic res_push,
  input  logic res_full
);

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int EntW = KeyBits + SsrcW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [EntW-1:0] mem [TABLE_DEPTH];

  logic [2:0]      state_r, state_nxt;
  cmd_t            cur_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   rd_idx_r, rd_idx_nxt;
  logic            d_vld_r;
  logic [EntW-1:0] rd_data_r;
  logic            found_r, found_nxt;
  logic            cand_r, cand_nxt;
  logic            ptmis_r, ptmis_nxt;
  res_t            res_r, res_nxt;
  logic            issuing, wr_en;
  logic [KeyBits-1:0] mask, st_key;
  logic [SsrcW-1:0]   st_ssrc;
  logic [7:0]         st_pt;
  logic               key_hit, ssrc_hit;

  always_comb begin
    for (int b = 0; b < KeyBytes; b++) begin
      mask[KeyBits-1-8*b -: 8] = (6'(b) < cur_r.key_len) ? 8'hff : 8'h00;
    end
  end

  assign st_key   = rd_data_r[EntW-1 -: KeyBits];
  assign st_ssrc  = rd_data_r[SsrcW-1:0];
  // payload type byte sits at key byte 36 (v6) or 12 (v4)
  assign st_pt    = cur_r.v6 ? st_key[KeyBits-1-8*36 -: 8] : st_key[KeyBits-1-8*12 -: 8];
  assign key_hit  = ((st_key ^ cur_r.key) & mask) == '0;
  assign ssrc_hit = (st_ssrc == cur_r.ssrc);
  assign issuing  = (state_r == S_SCAN) && (rd_idx_r < count_r) && !found_r;
  assign wr_en    = (state_r == S_DECIDE) && !found_r && !(cand_r && ssrc_join)
                    && (count_r < CW'(TABLE_DEPTH));

  assign cmd_pop  = (state_r == S_IDLE) && !cmd_empty;
  assign res      = res_r;
  assign res_push = (state_r == S_OUT) && !res_full;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    rd_idx_nxt = rd_idx_r;
    found_nxt  = found_r;
    cand_nxt   = cand_r;
    ptmis_nxt  = ptmis_r;
    res_nxt    = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt        = '0;
        res_nxt.status = ST_DONE;
        rd_idx_nxt     = '0;
        found_nxt      = 1'b0;
        cand_nxt       = 1'b0;
        ptmis_nxt      = 1'b0;
        state_nxt      = S_OUT;
        case (cur_r.op)
          OP_FIND: begin
            if (cur_r.rtcp) begin
              res_nxt.status = ST_RTCP;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          OP_REMOVE: begin
            if (count_r != '0) begin
              count_nxt = count_r - 1'b1;
            end
          end
          OP_RESET: count_nxt = '0;
          default: ;
        endcase
      end
      S_SCAN: begin
        if (issuing) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (d_vld_r && !found_r) begin
          if (key_hit) begin
            found_nxt = 1'b1;
          end
          if (ssrc_hit && !cand_r) begin
            cand_nxt  = 1'b1;
            ptmis_nxt = cur_r.pt_in_key && (st_pt != {1'b0, cur_r.pt});
          end
        end
        if (!issuing && !d_vld_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_OUT;
        res_nxt   = '0;
        if (found_r) begin
          res_nxt.status = ST_EXISTING;
        end else if (cand_r && ssrc_join) begin
          res_nxt.status      = ST_EXISTING;
          res_nxt.ssrc_match  = 1'b1;
          res_nxt.pt_mismatch = ptmis_r;
        end else if (count_r >= CW'(TABLE_DEPTH)) begin
          res_nxt.status = ST_FULL;
        end else begin
          res_nxt.status = ST_NEW;
          count_nxt      = count_r + 1'b1;
        end
      end
      S_OUT: begin
        if (!res_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_EXEC || state_r == S_DECIDE) begin
      res_nxt.stream_count = CountOutW'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      d_vld_r  <= 1'b0;
      rd_idx_r <= '0;
      found_r  <= 1'b0;
      cand_r   <= 1'b0;
      ptmis_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      d_vld_r  <= issuing;
      rd_idx_r <= rd_idx_nxt;
      found_r  <= found_nxt;
      cand_r   <= cand_nxt;
      ptmis_r  <= ptmis_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (cmd_pop) begin
      cur_r <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= {cur_r.key, cur_r.ssrc};
    end
    rd_data_r <= mem[rd_idx_r[AW-1:0]];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH)) else $error("entry count above table depth");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld_r |-> $past(state_r) == S_SCAN) else $error("read data outside scan");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> count_r == $past(count_r) + 1'b1) else $error("append without count bump");

  a_push_once: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> !res_push) else $error("result pushed twice");

endmodule

// ----- hdl/rtp_stream_key_table.sv -----
// Top level: RTP stream key table with config registers and queues.
// A find scans the stored entries in order and stops early on a key match:
// one stored entry is read from the table memory per cycle.
// Remove, reset and RTCP-rejected words go from execution to output without a scan.
// One word is worked at a time: a new word is taken only after the last result is pushed;
// 2-deep queues decouple both sides. Sync active-low reset empties table, clears config.
module rtp_stream_key_table
  import rsk_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_opcode,
  input  logic        in_is_ipv6,
  input  logic [63:0] in_src_addr_hi,
  input  logic [63:0] in_src_addr_lo,
  input  logic [63:0] in_dst_addr_hi,
  input  logic [63:0] in_dst_addr_lo,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [6:0]  in_payload_type,
  input  logic [31:0] in_sync_source,
  input  logic        in_is_dtmf,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_status,
  output logic [9:0]  out_stream_count,
  output logic        out_ssrc_match,
  output logic        out_payload_type_mismatch
);

  logic ssrc_join_r, excl_pt_r;
  cmd_t cmd_in, cmd_out;
  logic cmd_empty, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ssrc_join_r <= 1'b0;
      excl_pt_r   <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SSRC_JOIN) begin
        ssrc_join_r <= cfg_data;
      end
      if (cfg_index == CFG_EXCL_PT) begin
        excl_pt_r <= cfg_data;
      end
    end
  end

  rsk_front u_front (
    .opcode       (in_opcode),
    .is_ipv6      (in_is_ipv6),
    .src_addr_hi  (in_src_addr_hi),
    .src_addr_lo  (in_src_addr_lo),
    .dst_addr_hi  (in_dst_addr_hi),
    .dst_addr_lo  (in_dst_addr_lo),
    .src_port     (in_src_port),
    .dst_port     (in_dst_port),
    .rtp_pt       (in_payload_type),
    .sync_source  (in_sync_source),
    .is_dtmf      (in_is_dtmf),
    .excl_pt      (excl_pt_r),
    .cmd          (cmd_in)
  );

  rsk_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CmdQDepth)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  rsk_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ssrc_join (ssrc_join_r),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (res_in),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  rsk_fifo #(.WIDTH($bits(res_t)), .DEPTH(ResQDepth)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_status                = res_out.status;
  assign out_stream_count          = res_out.stream_count;
  assign out_ssrc_match            = res_out.ssrc_match;
  assign out_payload_type_mismatch = res_out.pt_mismatch;

endmodule
